### design/lzwd_pkg.sv
// lzwd_pkg: shared constants and types of the lzw code decoder
// no dependencies
`default_nettype none
package lzwd_pkg;
	localparam int DICT_ENTRIES = 3840;
	localparam int MAX_STRING   = 64;
	localparam int LITERALS     = 256;
	localparam int CODE_W       = 12;
	localparam int BYTE_W       = 8;
	localparam int LEN_W        = $clog2(MAX_STRING + 2);
	localparam int DICT_AW      = $clog2(DICT_ENTRIES);
	localparam int STACK_AW     = $clog2(MAX_STRING);

	typedef struct packed {
		logic [CODE_W-1:0] prefix;
		logic [BYTE_W-1:0] suffix;
		logic [BYTE_W-1:0] first;
		logic [LEN_W-1:0]  length;
	} entry_t;
endpackage
`default_nettype wire

### design/lzwd_ifs.sv
// lzwd_ifs: valid/ready channel interfaces for codes in and bytes out
// depends on lzwd_pkg
`default_nettype none
interface lzwd_code_if;
	logic                           valid;
	logic                           ready;
	logic [lzwd_pkg::CODE_W-1:0]    code_word;
	modport source (output valid, output code_word, input ready);
	modport sink (input valid, input code_word, output ready);
endinterface

interface lzwd_byte_if;
	logic                           valid;
	logic                           ready;
	logic [lzwd_pkg::BYTE_W-1:0]    out_byte;
	logic                           last_byte;
	logic                           corrupt;
	modport source (output valid, output out_byte, output last_byte, output corrupt, input ready);
	modport sink (input valid, input out_byte, input last_byte, input corrupt, output ready);
endinterface
`default_nettype wire

### design/lzw_code_decoder_unit.sv
// lzw_code_decoder_unit: 12-bit lzw code to byte string decoder
// depends on lzwd_pkg, lzwd_ifs, lzwd_dict
//
// code_in takes one 12-bit code per beat; byte_out gives the decoded string,
// one byte per beat, first byte first, last_byte set on the final one.
// a rejected code gives a single beat with corrupt and last_byte set and
// out_byte zero, and leaves the dictionary and history untouched.
// code_in.ready is high only while no code is in work, so codes are handled
// one at a time. a code of n bytes goes through lookup and entry write, a
// chain walk (one dictionary read per byte, the single read port sets this)
// and then a stack read plus a beat for each output byte. a rejected code
// goes from lookup straight to its corrupt beat.
// when byte_out.ready is low the current beat holds and the block waits.
// reset clears the history and the free-entry count; dictionary and stack
// contents are not cleared, since no valid code reaches an unwritten entry.
// when the dictionary fills it starts over and the next code is a literal.
`default_nettype none
module lzw_code_decoder_unit (
	input  wire logic     clk,
	input  wire logic     arst_n,
	lzwd_code_if.sink     code_in,
	lzwd_byte_if.source   byte_out
);
	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_DECIDE = 7'b0000010,
		S_WREAD  = 7'b0000100,
		S_WALK   = 7'b0001000,
		S_RD     = 7'b0010000,
		S_SHOW   = 7'b0100000,
		S_REJ    = 7'b1000000
	} state_t;

	localparam logic [lzwd_pkg::CODE_W-1:0] LIT_BASE = lzwd_pkg::CODE_W'(lzwd_pkg::LITERALS);
	localparam logic [lzwd_pkg::CODE_W-1:0] NF_LAST  =
		lzwd_pkg::CODE_W'(lzwd_pkg::DICT_ENTRIES - 1);

	state_t                         state_q;
	logic [lzwd_pkg::CODE_W-1:0]    code_q;
	logic [lzwd_pkg::CODE_W-1:0]    prev_q;
	logic [lzwd_pkg::LEN_W-1:0]     prev_len_q;
	logic [lzwd_pkg::BYTE_W-1:0]    prev_first_q;
	logic                           have_q;
	logic [lzwd_pkg::CODE_W-1:0]    nf_q;
	logic [lzwd_pkg::CODE_W-1:0]    walk_c_q;
	logic [lzwd_pkg::LEN_W-1:0]     walk_i_q;
	logic [lzwd_pkg::LEN_W-1:0]     len_q;
	logic [lzwd_pkg::STACK_AW-1:0]  out_j_q;
	logic [lzwd_pkg::BYTE_W-1:0]    stack_rd_q;
	logic [lzwd_pkg::BYTE_W-1:0]    stack [lzwd_pkg::MAX_STRING];

	// dictionary port
	logic                           dict_we;
	logic [lzwd_pkg::CODE_W-1:0]    rd_code;
	lzwd_pkg::entry_t               wr_entry;
	lzwd_pkg::entry_t               rd_entry;

	// decision on the code in hand
	logic [lzwd_pkg::CODE_W-1:0]    idx;
	logic                           lit;
	logic [lzwd_pkg::LEN_W-1:0]     d_len;
	logic [lzwd_pkg::BYTE_W-1:0]    d_first;
	logic                           d_bad;

	// chain walk
	logic                           walk_lit;
	logic [lzwd_pkg::BYTE_W-1:0]    walk_byte;
	logic                           out_last;

	assign idx = code_q - LIT_BASE;
	assign lit = code_q < LIT_BASE;

	always_comb begin
		d_len   = lzwd_pkg::LEN_W'(1);
		d_first = code_q[lzwd_pkg::BYTE_W-1:0];
		d_bad   = 1'b0;
		if (!have_q) begin
			d_bad = !lit;
		end else if (!lit) begin
			if (idx < nf_q) begin
				d_len   = rd_entry.length;
				d_first = rd_entry.first;
			end else if (idx == nf_q) begin
				d_len   = prev_len_q + lzwd_pkg::LEN_W'(1);
				d_first = prev_first_q;
			end else begin
				d_bad = 1'b1;
			end
		end
		if (d_len > lzwd_pkg::LEN_W'(lzwd_pkg::MAX_STRING)) begin
			d_bad = 1'b1;
		end
	end

	// new entry: previous string plus first byte of this one
	assign wr_entry.prefix = prev_q;
	assign wr_entry.suffix = d_first;
	assign wr_entry.first  = prev_first_q;
	assign wr_entry.length = prev_len_q + lzwd_pkg::LEN_W'(1);
	assign dict_we = (state_q == S_DECIDE) && have_q && !d_bad;

	assign walk_lit  = walk_c_q < LIT_BASE;
	assign walk_byte = walk_lit ? walk_c_q[lzwd_pkg::BYTE_W-1:0] : rd_entry.suffix;

	// read address: the code on accept, the walk start, then each prefix in turn
	always_comb begin
		unique case (state_q)
			S_IDLE:  rd_code = code_in.code_word - LIT_BASE;
			S_WREAD: rd_code = walk_c_q - LIT_BASE;
			S_WALK:  rd_code = rd_entry.prefix - LIT_BASE;
			default: rd_code = idx;
		endcase
	end

	lzwd_dict u_dict (
		.clk     (clk),
		.wr_en   (dict_we),
		.wr_addr (nf_q[lzwd_pkg::DICT_AW-1:0]),
		.wr_data (wr_entry),
		.rd_addr (rd_code[lzwd_pkg::DICT_AW-1:0]),
		.rd_data (rd_entry)
	);

	// reverse stack: filled last byte first, read out in order
	always_ff @(posedge clk) begin
		if (state_q == S_WALK) begin
			stack[lzwd_pkg::STACK_AW'(walk_i_q - lzwd_pkg::LEN_W'(1))] <= walk_byte;
		end
		stack_rd_q <= stack[out_j_q];
	end

	assign out_last = (lzwd_pkg::LEN_W'(out_j_q) + lzwd_pkg::LEN_W'(1)) == len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			prev_q       <= '0;
			prev_len_q   <= lzwd_pkg::LEN_W'(1);
			prev_first_q <= '0;
			have_q       <= 1'b0;
			nf_q         <= '0;
			code_q       <= '0;
			walk_c_q     <= '0;
			walk_i_q     <= '0;
			len_q        <= '0;
			out_j_q      <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (code_in.valid) begin
						code_q  <= code_in.code_word;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (d_bad) begin
						state_q <= S_REJ;
					end else begin
						prev_q       <= code_q;
						prev_len_q   <= d_len;
						prev_first_q <= d_first;
						walk_c_q     <= code_q;
						walk_i_q     <= d_len;
						len_q        <= d_len;
						if (!have_q) begin
							have_q <= 1'b1;
						end else if (nf_q == NF_LAST) begin
							// dictionary full: start over with a literal
							nf_q   <= '0;
							have_q <= 1'b0;
						end else begin
							nf_q <= nf_q + lzwd_pkg::CODE_W'(1);
						end
						state_q <= S_WREAD;
					end
				end
				S_WREAD: begin
					state_q <= S_WALK;
				end
				S_WALK: begin
					walk_c_q <= rd_entry.prefix;
					if (walk_i_q == lzwd_pkg::LEN_W'(1)) begin
						out_j_q <= '0;
						state_q <= S_RD;
					end else begin
						walk_i_q <= walk_i_q - lzwd_pkg::LEN_W'(1);
					end
				end
				S_RD: begin
					state_q <= S_SHOW;
				end
				S_SHOW: begin
					if (byte_out.ready) begin
						if (out_last) begin
							state_q <= S_IDLE;
						end else begin
							out_j_q <= out_j_q + lzwd_pkg::STACK_AW'(1);
							state_q <= S_RD;
						end
					end
				end
				S_REJ: begin
					if (byte_out.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign code_in.ready      = (state_q == S_IDLE);
	assign byte_out.valid     = (state_q == S_SHOW) || (state_q == S_REJ);
	assign byte_out.corrupt   = (state_q == S_REJ);
	assign byte_out.out_byte  = (state_q == S_REJ) ? '0 : stack_rd_q;
	assign byte_out.last_byte = (state_q == S_REJ) || out_last;
endmodule
`default_nettype wire

### design/lzwd_dict.sv
// lzwd_dict: dictionary memory, one write and one registered read port
// depends on lzwd_pkg
`default_nettype none
module lzwd_dict (
	input  wire logic                         clk,
	input  wire logic                         wr_en,
	input  wire logic [lzwd_pkg::DICT_AW-1:0] wr_addr,
	input  wire lzwd_pkg::entry_t             wr_data,
	input  wire logic [lzwd_pkg::DICT_AW-1:0] rd_addr,
	output lzwd_pkg::entry_t                  rd_data
);
	lzwd_pkg::entry_t mem [lzwd_pkg::DICT_ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule
`default_nettype wire

### design/lzwd_checker.sv
// lzwd_checker: port-level checks of the lzw code decoder, bound to the top
// depends on lzwd_pkg and lzw_code_decoder_unit
`default_nettype none
module lzwd_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_valid,
	input wire logic                         in_ready,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic [lzwd_pkg::BYTE_W-1:0]  out_byte,
	input wire logic                         last_byte,
	input wire logic                         corrupt
);
	// a stalled beat holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_byte)
			&& $stable(corrupt))
		else $error("stalled output beat changed");

	// a rejected code is one zero beat that ends the string
	a_rej: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && corrupt |-> last_byte && out_byte == '0)
		else $error("corrupt beat malformed");

	// one code at a time: no new code taken right after one is taken
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	// no code taken while a string is being delivered
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready during output");
endmodule

bind lzw_code_decoder_unit lzwd_checker u_lzwd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (code_in.valid),
	.in_ready  (code_in.ready),
	.out_valid (byte_out.valid),
	.out_ready (byte_out.ready),
	.out_byte  (byte_out.out_byte),
	.last_byte (byte_out.last_byte),
	.corrupt   (byte_out.corrupt)
);
`default_nettype wire

### dv/lzw_code_decoder_unit_test.sv
// lzw_code_decoder_unit_test: self-checking bench for the lzw code decoder
// drives codes and checks byte beats against a local decoder model
// depends on lzwd_pkg, lzwd_ifs and the lzw_code_decoder_unit rtl
`default_nettype none
module lzw_code_decoder_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 200;

	typedef struct {
		logic [lzwd_pkg::BYTE_W-1:0] out_byte;
		logic                        last_byte;
		logic                        corrupt;
	} byte_beat_t;

	logic clk;
	logic arst_n;

	lzwd_code_if code_ch ();
	lzwd_byte_if byte_ch ();

	lzw_code_decoder_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.code_in  (code_ch),
		.byte_out (byte_ch)
	);

	// decoder model state
	logic [lzwd_pkg::CODE_W-1:0] link_tab [lzwd_pkg::DICT_ENTRIES];
	logic [lzwd_pkg::BYTE_W-1:0] tail_tab [lzwd_pkg::DICT_ENTRIES];
	logic [lzwd_pkg::BYTE_W-1:0] head_tab [lzwd_pkg::DICT_ENTRIES];
	logic [6:0]                  size_tab [lzwd_pkg::DICT_ENTRIES];
	logic [lzwd_pkg::CODE_W-1:0] prev_code;
	logic                        have_prev;
	int                          free_idx;

	logic [lzwd_pkg::CODE_W-1:0] pending_codes [$];
	byte_beat_t                  byte_expect [$];
	int                          errors;
	int                          idle_cycles;
	int                          send_gap;
	int                          rdy_gap;
	bit                          taken;
	bit                          quiet;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// string length of a code, literals are one byte
	function automatic int str_length(input int c);
		if (c < lzwd_pkg::LITERALS)
			return 1;
		return int'(size_tab[c - lzwd_pkg::LITERALS]);
	endfunction

	function automatic logic [lzwd_pkg::BYTE_W-1:0] str_head(input int c);
		if (c < lzwd_pkg::LITERALS)
			return lzwd_pkg::BYTE_W'(c);
		return head_tab[c - lzwd_pkg::LITERALS];
	endfunction

	function automatic void push_beat(input logic [lzwd_pkg::BYTE_W-1:0] b, input logic l,
			input logic k);
		byte_beat_t e;
		e.out_byte = b;
		e.last_byte = l;
		e.corrupt = k;
		byte_expect.insert(byte_expect.size(), e);
	endfunction

	// update the model for one accepted code and queue its byte beats
	function automatic void decode_code(input logic [lzwd_pkg::CODE_W-1:0] code);
		int nf;
		int len;
		int c;
		logic [lzwd_pkg::BYTE_W-1:0] tail;
		logic [lzwd_pkg::BYTE_W-1:0] stack [lzwd_pkg::MAX_STRING];
		nf = free_idx;
		if (!have_prev) begin
			if (code >= lzwd_pkg::LITERALS) begin
				push_beat('0, 1'b1, 1'b1);
				return;
			end
			prev_code = code;
			have_prev = 1'b1;
			push_beat(lzwd_pkg::BYTE_W'(code), 1'b1, 1'b0);
			return;
		end
		if (code < lzwd_pkg::LITERALS) begin
			len = 1;
			tail = lzwd_pkg::BYTE_W'(code);
		end else if (int'(code) - lzwd_pkg::LITERALS < nf) begin
			len = str_length(code);
			tail = str_head(code);
		end else if (int'(code) - lzwd_pkg::LITERALS == nf) begin
			// code names the entry being defined right now
			len = str_length(prev_code) + 1;
			tail = str_head(prev_code);
		end else begin
			push_beat('0, 1'b1, 1'b1);
			return;
		end
		if (len > lzwd_pkg::MAX_STRING) begin
			push_beat('0, 1'b1, 1'b1);
			return;
		end
		link_tab[nf] = prev_code;
		tail_tab[nf] = tail;
		head_tab[nf] = str_head(prev_code);
		size_tab[nf] = 7'(str_length(prev_code) + 1);
		c = code;
		for (int i = len; i > 0; i--) begin
			if (c < lzwd_pkg::LITERALS) begin
				stack[i-1] = lzwd_pkg::BYTE_W'(c);
			end else begin
				stack[i-1] = tail_tab[c - lzwd_pkg::LITERALS];
				c = link_tab[c - lzwd_pkg::LITERALS];
			end
		end
		for (int i = 0; i < len; i++)
			push_beat(stack[i], (i == len - 1), 1'b0);
		prev_code = code;
		nf++;
		if (nf >= lzwd_pkg::DICT_ENTRIES) begin
			// dictionary full, start a fresh run
			nf = 0;
			have_prev = 1'b0;
		end
		free_idx = nf;
	endfunction

	// code accept side and watchdog, sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (code_ch.valid && code_ch.ready) begin
				decode_code(pending_codes.pop_front());
				taken = 1'b1;
				idle_cycles = 0;
			end else if (!(byte_ch.valid && byte_ch.ready)) begin
				idle_cycles++;
				if (idle_cycles >= STALL_LIMIT) begin
					$display("RESULT: ERROR");
					$finish;
				end
			end
		end
	end

	// code driver: a beat holds until taken, then maybe an idle burst
	always @(negedge clk) begin
		if (!arst_n) begin
			code_ch.valid <= 1'b0;
		end else if (!code_ch.valid || taken) begin
			if (!quiet && send_gap > 0) begin
				code_ch.valid <= 1'b0;
				send_gap--;
				taken = 1'b0;
			end else if (pending_codes.size() > 0) begin
				code_ch.valid <= 1'b1;
				code_ch.code_word <= pending_codes[0];
				taken = 1'b0;
				if (!quiet && $urandom_range(0, 3) == 0)
					send_gap = $urandom_range(1, 18);
			end else begin
				code_ch.valid <= 1'b0;
				taken = 1'b0;
			end
		end
	end

	// byte sink ready with random stall bursts
	always @(negedge clk) begin
		if (!quiet && rdy_gap > 0) begin
			byte_ch.ready <= 1'b0;
			rdy_gap--;
		end else begin
			byte_ch.ready <= 1'b1;
			if (!quiet && $urandom_range(0, 15) == 0)
				rdy_gap = $urandom_range(1, 18);
		end
	end

	// byte monitor, compares every beat against the oldest expectation
	always @(posedge clk) begin
		byte_beat_t e;
		if (arst_n && byte_ch.valid && byte_ch.ready) begin
			if (byte_expect.size() == 0) begin
				$error("byte beat with nothing expected: out_byte %0h", byte_ch.out_byte);
				errors++;
			end else begin
				e = byte_expect.pop_front();
				if (byte_ch.out_byte !== e.out_byte) begin
					$error("out_byte expected %0h actual %0h", e.out_byte, byte_ch.out_byte);
					errors++;
				end
				if (byte_ch.last_byte !== e.last_byte) begin
					$error("last_byte expected %0b actual %0b", e.last_byte,
						byte_ch.last_byte);
					errors++;
				end
				if (byte_ch.corrupt !== e.corrupt) begin
					$error("corrupt expected %0b actual %0b", e.corrupt, byte_ch.corrupt);
					errors++;
				end
			end
		end
	end

	// hand one code to the driver and wait until the block takes it
	task automatic send(input int c);
		pending_codes.insert(pending_codes.size(), lzwd_pkg::CODE_W'(c));
		wait (pending_codes.size() == 0);
	endtask

	// mostly codes the dictionary knows, some noise
	function automatic int pick_code();
		int r;
		if (!have_prev)
			return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 255);
		r = $urandom_range(0, 9);
		if (r < 3)
			return $urandom_range(0, 255);
		if (r < 8)
			return lzwd_pkg::LITERALS + $urandom_range(0, free_idx);
		return $urandom_range(0, 4095);
	endfunction

	initial begin
		int e;
		arst_n = 1'b0;
		code_ch.valid = 1'b0;
		code_ch.code_word = '0;
		byte_ch.ready = 1'b0;
		prev_code = '0;
		have_prev = 1'b0;
		free_idx = 0;
		errors = 0;
		idle_cycles = 0;
		send_gap = 0;
		rdy_gap = 0;
		taken = 1'b0;
		quiet = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: non-literal first code, extremes, known entry, self-reference
		send(lzwd_pkg::LITERALS);
		send(4095);
		send(0);
		send(255);
		send(lzwd_pkg::LITERALS);
		send(lzwd_pkg::LITERALS + free_idx);
		send(lzwd_pkg::LITERALS + free_idx + 1);
		send(4095);
		send(8'hAA);
		send(8'h55);
		send(lzwd_pkg::LITERALS + 1);
		// grow a chain of self-referencing codes up to the longest string
		while (str_length(prev_code) + 1 <= lzwd_pkg::MAX_STRING)
			send(lzwd_pkg::LITERALS + free_idx);
		send(lzwd_pkg::LITERALS + free_idx);
		// entry one byte too long, then a code that names it
		send(8'h41);
		e = free_idx - 1;
		send(lzwd_pkg::LITERALS + e);

		// random codes
		for (int i = 0; i < 20; i++)
			send(pick_code());
		// let everything drain before going on
		wait (byte_expect.size() == 0);
		for (int i = 0; i < 15; i++)
			send(pick_code());

		// last part without any idling
		wait (byte_expect.size() == 0);
		quiet = 1'b1;
		for (int i = 0; i < 10; i++)
			send(pick_code());

		wait (byte_expect.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && byte_expect.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
`default_nettype wire

### lzw_code_decoder_unit.f
design/lzwd_pkg.sv
design/lzwd_ifs.sv
design/lzwd_dict.sv
design/lzw_code_decoder_unit.sv
design/lzwd_checker.sv
dv/lzw_code_decoder_unit_test.sv
